// ----- rtl/scfr_pkg.sv -----
// Shared types and constants of the sum-checked frame receiver.
package scfr_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 6;
    localparam int SUM_W  = 16;

    localparam logic [BYTE_W-1:0] SYNC_RESET = 8'hAA;

    // Depth of the descriptor queue between front and back.
    localparam int DESC_DEPTH = 2;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_LEN  = 3'd1,
        PH_DATA = 3'd2,
        PH_CKLO = 3'd3,
        PH_CKHI = 3'd4
    } t_phase;

    // Outcome of one finished frame, handed from front to back.
    typedef struct packed {
        logic             mismatch;
        logic [LEN_W-1:0] len;
    } t_desc;

endpackage

// ----- rtl/sum_checked_frame_receiver.sv -----
// Top level of the sum-checked frame receiver.
//
// Received bytes enter through push/full, one byte per accepted item. The block
// hunts for the sync byte, reads a length byte (clamped to MAX_PAYLOAD), stores
// the payload and checks the 16-bit byte sum sent low byte first.
// Results leave through empty/pop: a good frame gives its payload bytes, the
// final one marked last; an empty good frame gives one result without data; a
// failed checksum gives one result with frame_status set.
// The sync byte is written through i_cfg_valid/o_cfg_ready; ready is always high.
// Every byte is taken in the cycle it is pushed, except that payload bytes wait
// (full high) while an earlier frame is queued or replaying, as both use the one
// payload RAM, and the high checksum byte waits while the descriptor queue is full.
// A finished frame passes through the descriptor queue to the back part, which
// loads a single result straight into the output register; a payload frame is
// replayed by reading one byte at a time from the registered RAM, the next read
// waiting until the last has landed and the output register will be free.
// If the receiver stalls, the output register holds its result and the front
// keeps taking bytes until it reaches payload or the two-entry descriptor queue
// is full. Synchronous reset returns to sync hunting with no pending results
// and restores the sync byte to 0xAA; the payload RAM is not cleared.
module sum_checked_frame_receiver #(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [scfr_pkg::BYTE_W-1:0] i_cfg_sync_byte,
    input  logic                        push,
    output logic                        full,
    input  logic [scfr_pkg::BYTE_W-1:0] i_rx_byte,
    output logic                        empty,
    input  logic                        pop,
    output logic [scfr_pkg::BYTE_W-1:0] o_data_byte,
    output logic                        o_has_data,
    output logic                        o_last,
    output logic                        o_frame_status,
    output logic [scfr_pkg::LEN_W-1:0]  o_frame_length
);

    localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic                        w_we, w_re;
    logic [ADDR_W-1:0]           w_waddr, w_raddr;
    logic [scfr_pkg::BYTE_W-1:0] w_wdata, w_rdata;
    logic                        w_desc_push, w_desc_full, w_desc_valid, w_desc_pop;
    scfr_pkg::t_desc             w_desc_in, w_desc_out;
    logic                        w_back_busy;

    assign o_cfg_ready = 1'b1;

    scfr_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_sync_byte (i_cfg_sync_byte),
        .i_push          (push),
        .o_full          (full),
        .i_rx_byte       (i_rx_byte),
        .o_we            (w_we),
        .o_waddr         (w_waddr),
        .o_wdata         (w_wdata),
        .o_desc_push     (w_desc_push),
        .o_desc          (w_desc_in),
        .i_desc_full     (w_desc_full),
        .i_back_busy     (w_back_busy)
    );

    scfr_ram #(.WIDTH(scfr_pkg::BYTE_W), .DEPTH(MAX_PAYLOAD)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    scfr_desc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_desc_push),
        .i_desc  (w_desc_in),
        .o_full  (w_desc_full),
        .i_pop   (w_desc_pop),
        .o_valid (w_desc_valid),
        .o_desc  (w_desc_out)
    );

    scfr_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_desc_valid   (w_desc_valid),
        .i_desc         (w_desc_out),
        .o_desc_pop     (w_desc_pop),
        .o_busy         (w_back_busy),
        .o_re           (w_re),
        .o_raddr        (w_raddr),
        .i_rdata        (w_rdata),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_data_byte    (o_data_byte),
        .o_has_data     (o_has_data),
        .o_last         (o_last),
        .o_frame_status (o_frame_status),
        .o_frame_length (o_frame_length)
    );

endmodule

// ----- rtl/scfr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module scfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/scfr_front.sv -----
// Front part: sync hunt, length, payload capture, checksum check.
module scfr_front #(
    parameter int MAX_PAYLOAD = 32,
    localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    input  logic [scfr_pkg::BYTE_W-1:0] i_cfg_sync_byte,
    input  logic                       i_push,
    output logic                       o_full,
    input  logic [scfr_pkg::BYTE_W-1:0] i_rx_byte,
    output logic                       o_we,
    output logic [ADDR_W-1:0]          o_waddr,
    output logic [scfr_pkg::BYTE_W-1:0] o_wdata,
    output logic                       o_desc_push,
    output scfr_pkg::t_desc            o_desc,
    input  logic                       i_desc_full,
    input  logic                       i_back_busy
);

    scfr_pkg::t_phase                r_phase, n_phase;
    logic [scfr_pkg::BYTE_W-1:0]    r_sync;
    logic [scfr_pkg::LEN_W-1:0]     r_exp_len, n_exp_len;
    logic [scfr_pkg::LEN_W-1:0]     r_count, n_count;
    logic [scfr_pkg::SUM_W-1:0]     r_sum, n_sum;
    logic [scfr_pkg::BYTE_W-1:0]    r_ck_lo, n_ck_lo;
    logic                           w_accept;
    logic [scfr_pkg::LEN_W-1:0]     w_clamped;
    logic [scfr_pkg::SUM_W-1:0]     w_got;

    // Payload waits while a frame is queued or replaying; the high sum byte waits on a full queue.
    assign o_full = ((r_phase == scfr_pkg::PH_DATA) && i_back_busy) ||
                    ((r_phase == scfr_pkg::PH_CKHI) && i_desc_full);
    assign w_accept = i_push && !o_full;

    assign w_clamped = (i_rx_byte > scfr_pkg::BYTE_W'(MAX_PAYLOAD)) ?
                       scfr_pkg::LEN_W'(MAX_PAYLOAD) : i_rx_byte[scfr_pkg::LEN_W-1:0];
    assign w_got = {i_rx_byte, r_ck_lo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= scfr_pkg::PH_HUNT;
            r_sync    <= scfr_pkg::SYNC_RESET;
            r_exp_len <= '0;
            r_count   <= '0;
            r_sum     <= '0;
            r_ck_lo   <= '0;
        end else begin
            r_phase   <= n_phase;
            r_exp_len <= n_exp_len;
            r_count   <= n_count;
            r_sum     <= n_sum;
            r_ck_lo   <= n_ck_lo;
            if (i_cfg_valid) begin
                r_sync <= i_cfg_sync_byte;
            end
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_exp_len   = r_exp_len;
        n_count     = r_count;
        n_sum       = r_sum;
        n_ck_lo     = r_ck_lo;
        o_we        = 1'b0;
        o_waddr     = r_count[ADDR_W-1:0];
        o_wdata     = i_rx_byte;
        o_desc_push = 1'b0;
        o_desc      = '{mismatch: (w_got != r_sum), len: r_exp_len};
        case (r_phase)
            scfr_pkg::PH_HUNT: begin
                if (w_accept && (i_rx_byte == r_sync)) begin
                    n_phase = scfr_pkg::PH_LEN;
                    n_sum   = '0;
                    n_count = '0;
                end
            end
            scfr_pkg::PH_LEN: begin
                if (w_accept) begin
                    n_exp_len = w_clamped;
                    n_count   = '0;
                    n_sum     = '0;
                    n_phase   = (w_clamped == '0) ? scfr_pkg::PH_CKLO : scfr_pkg::PH_DATA;
                end
            end
            scfr_pkg::PH_DATA: begin
                if (w_accept) begin
                    o_we    = 1'b1;
                    n_sum   = r_sum + scfr_pkg::SUM_W'(i_rx_byte);
                    n_count = r_count + scfr_pkg::LEN_W'(1);
                    if (n_count >= r_exp_len) begin
                        n_phase = scfr_pkg::PH_CKLO;
                    end
                end
            end
            scfr_pkg::PH_CKLO: begin
                if (w_accept) begin
                    n_ck_lo = i_rx_byte;
                    n_phase = scfr_pkg::PH_CKHI;
                end
            end
            scfr_pkg::PH_CKHI: begin
                if (w_accept) begin
                    o_desc_push = 1'b1;
                    n_phase     = scfr_pkg::PH_HUNT;
                    n_count     = '0;
                    n_sum       = '0;
                end
            end
            default: begin
                n_phase = scfr_pkg::PH_HUNT;
            end
        endcase
    end

endmodule

// ----- rtl/scfr_desc_fifo.sv -----
// Short queue of frame descriptors between the front and back parts.
module scfr_desc_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  scfr_pkg::t_desc i_desc,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output scfr_pkg::t_desc o_desc
);

    localparam int PTR_W = (scfr_pkg::DESC_DEPTH > 1) ? $clog2(scfr_pkg::DESC_DEPTH) : 1;
    localparam int CNT_W = $clog2(scfr_pkg::DESC_DEPTH + 1);

    scfr_pkg::t_desc  r_mem [scfr_pkg::DESC_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push, w_pop;

    assign o_full  = (r_count == CNT_W'(scfr_pkg::DESC_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_desc  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(scfr_pkg::DESC_DEPTH - 1)) ?
                            '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(scfr_pkg::DESC_DEPTH - 1)) ?
                            '0 : r_rd_ptr + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ----- rtl/scfr_back.sv -----
// Back part: replays verified payloads and reports empty or failed frames.
module scfr_back #(
    parameter int MAX_PAYLOAD = 32,
    localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_desc_valid,
    input  scfr_pkg::t_desc             i_desc,
    output logic                        o_desc_pop,
    output logic                        o_busy,
    output logic                        o_re,
    output logic [ADDR_W-1:0]           o_raddr,
    input  logic [scfr_pkg::BYTE_W-1:0] i_rdata,
    input  logic                        i_pop,
    output logic                        o_empty,
    output logic [scfr_pkg::BYTE_W-1:0] o_data_byte,
    output logic                        o_has_data,
    output logic                        o_last,
    output logic                        o_frame_status,
    output logic [scfr_pkg::LEN_W-1:0]  o_frame_length
);

    logic                        r_active;
    logic                        r_rd_pend;
    logic                        r_pend_last;
    logic [scfr_pkg::LEN_W-1:0]  r_idx;
    logic [scfr_pkg::LEN_W-1:0]  r_len;
    logic                        r_out_valid;
    logic [scfr_pkg::BYTE_W-1:0] r_data;
    logic                        r_has, r_last, r_status;
    logic [scfr_pkg::LEN_W-1:0]  r_out_len;
    logic                        w_out_pop, w_can_load, w_issue, w_start, w_single;
    logic [scfr_pkg::LEN_W-1:0]  w_idx_next;

    assign w_out_pop  = i_pop && r_out_valid;
    assign w_can_load = !r_out_valid || w_out_pop;
    // A read is issued only when the output register will be free as the data lands.
    assign w_issue    = r_active && !r_rd_pend && w_can_load;
    assign w_idx_next = r_idx + scfr_pkg::LEN_W'(1);
    assign w_single   = i_desc.mismatch || (i_desc.len == '0);
    assign w_start    = !r_active && !r_rd_pend && i_desc_valid &&
                        (!w_single || w_can_load);

    assign o_desc_pop = w_start;
    assign o_busy     = i_desc_valid || r_active;
    assign o_re       = w_issue;
    assign o_raddr    = r_idx[ADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_pend <= w_issue;
            if (w_issue && (w_idx_next == r_len)) begin
                r_active <= 1'b0;
            end else if (w_start && !w_single) begin
                r_active <= 1'b1;
            end
            if (r_rd_pend || (w_start && w_single)) begin
                r_out_valid <= 1'b1;
            end else if (w_out_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_idx <= '0;
            r_len <= i_desc.len;
        end else if (w_issue) begin
            r_idx <= w_idx_next;
        end
        if (w_issue) begin
            r_pend_last <= (w_idx_next == r_len);
        end
        if (r_rd_pend) begin
            r_data    <= i_rdata;
            r_has     <= 1'b1;
            r_last    <= r_pend_last;
            r_status  <= 1'b0;
            r_out_len <= r_len;
        end else if (w_start && w_single) begin
            r_data    <= '0;
            r_has     <= 1'b0;
            r_last    <= 1'b1;
            r_status  <= i_desc.mismatch;
            r_out_len <= i_desc.len;
        end
    end

    assign o_empty        = !r_out_valid;
    assign o_data_byte    = r_data;
    assign o_has_data     = r_has;
    assign o_last         = r_last;
    assign o_frame_status = r_status;
    assign o_frame_length = r_out_len;

endmodule

// ----- rtl/scfr_checker.sv -----
// Port-level assertions for the frame receiver, bound to the top level.
module scfr_checker #(
    parameter int MAX_PAYLOAD = 32
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        empty,
    input logic                        pop,
    input logic [scfr_pkg::BYTE_W-1:0] o_data_byte,
    input logic                        o_has_data,
    input logic                        o_last,
    input logic                        o_frame_status,
    input logic [scfr_pkg::LEN_W-1:0]  o_frame_length
);

    // Reset leaves no result waiting.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result pending after reset");

    // A failed frame is reported by one closing item without data.
    a_fail_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_frame_status) |-> (!o_has_data && o_last))
        else $error("checksum failure item malformed");

    // Items without data carry a zero data byte and close the frame.
    a_nodata_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_has_data) |-> (o_data_byte == '0 && o_last))
        else $error("item without data malformed");

    // Reported lengths never exceed the payload store.
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_frame_length <= scfr_pkg::LEN_W'(MAX_PAYLOAD)))
        else $error("frame length above store size");

    // A waiting item holds until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_data_byte) && $stable(o_last)))
        else $error("waiting item changed");

endmodule

bind sum_checked_frame_receiver scfr_checker #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_scfr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .empty          (empty),
    .pop            (pop),
    .o_data_byte    (o_data_byte),
    .o_has_data     (o_has_data),
    .o_last         (o_last),
    .o_frame_status (o_frame_status),
    .o_frame_length (o_frame_length)
);

// ----- test/sum_checked_frame_receiver_tb.sv -----
// Self-checking testbench for the sum-checked frame receiver.
`timescale 1ns / 1ps

module sum_checked_frame_receiver_tb;

    localparam int MAX_PAYLOAD = 32;
    localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_PAD   = 16;

    typedef struct packed {
        logic [scfr_pkg::BYTE_W-1:0] data_byte;
        logic                        has_data;
        logic                        last;
        logic                        frame_status;
        logic [scfr_pkg::LEN_W-1:0]  frame_length;
    } t_frame_result;

    typedef enum logic [1:0] {
        FILL_CONST = 2'd0,
        FILL_RAMP  = 2'd1,
        FILL_RAND  = 2'd2
    } t_fill;

    typedef struct packed {
        logic [2:0]    noise_n;
        logic [7:0]    len_byte;
        t_fill         fill;
        logic [7:0]    seed;
        logic          bad_sum;
        logic          typed;
        t_frame_result want;
    } t_frame_row;

    localparam int PLAN_ROWS = 12;

    // Typed results are single-result frames: empty frames, dropped frames and
    // one-byte frames. The rest go through the frame model.
    t_frame_row frame_plan [0:PLAN_ROWS-1] = '{
        {3'd3, 8'd0,   FILL_CONST, 8'h00, 1'b0, 1'b1, {8'h00, 1'b0, 1'b1, 1'b0, 6'd0}},
        {3'd0, 8'd0,   FILL_CONST, 8'h00, 1'b1, 1'b1, {8'h00, 1'b0, 1'b1, 1'b1, 6'd0}},
        {3'd0, 8'd1,   FILL_CONST, 8'hFF, 1'b0, 1'b1, {8'hFF, 1'b1, 1'b1, 1'b0, 6'd1}},
        {3'd1, 8'd1,   FILL_CONST, 8'h00, 1'b0, 1'b1, {8'h00, 1'b1, 1'b1, 1'b0, 6'd1}},
        {3'd0, 8'd32,  FILL_CONST, 8'hFF, 1'b0, 1'b0, {8'h00, 1'b0, 1'b0, 1'b0, 6'd0}},
        {3'd0, 8'd255, FILL_RAND,  8'h00, 1'b1, 1'b1, {8'h00, 1'b0, 1'b1, 1'b1, 6'd32}},
        {3'd2, 8'd33,  FILL_RAMP,  8'hAA, 1'b0, 1'b0, {8'h00, 1'b0, 1'b0, 1'b0, 6'd0}},
        {3'd0, 8'hAA,  FILL_RAMP,  8'h01, 1'b1, 1'b1, {8'h00, 1'b0, 1'b1, 1'b1, 6'd32}},
        {3'd0, 8'd5,   FILL_RAMP,  8'hFC, 1'b0, 1'b0, {8'h00, 1'b0, 1'b0, 1'b0, 6'd0}},
        {3'd0, 8'd3,   FILL_CONST, 8'h00, 1'b0, 1'b0, {8'h00, 1'b0, 1'b0, 1'b0, 6'd0}},
        {3'd1, 8'd2,   FILL_CONST, 8'h80, 1'b1, 1'b1, {8'h00, 1'b0, 1'b1, 1'b1, 6'd2}},
        {3'd0, 8'd31,  FILL_RAMP,  8'h10, 1'b0, 1'b0, {8'h00, 1'b0, 1'b0, 1'b0, 6'd0}}
    };

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        i_cfg_valid;
    logic                        o_cfg_ready;
    logic [scfr_pkg::BYTE_W-1:0] i_cfg_sync_byte;
    logic                        push;
    logic                        full;
    logic [scfr_pkg::BYTE_W-1:0] i_rx_byte;
    logic                        empty;
    logic                        pop;
    logic [scfr_pkg::BYTE_W-1:0] o_data_byte;
    logic                        o_has_data;
    logic                        o_last;
    logic                        o_frame_status;
    logic [scfr_pkg::LEN_W-1:0]  o_frame_length;

    // Frame model state.
    scfr_pkg::t_phase            rx_phase = scfr_pkg::PH_HUNT;
    logic [scfr_pkg::BYTE_W-1:0] sync_now = scfr_pkg::SYNC_RESET;
    logic [scfr_pkg::LEN_W-1:0]  want_len = '0;
    logic [scfr_pkg::LEN_W-1:0]  got_count = '0;
    logic [scfr_pkg::SUM_W-1:0]  byte_sum = '0;
    logic [scfr_pkg::BYTE_W-1:0] sum_lo = '0;
    logic [scfr_pkg::BYTE_W-1:0] payload_mem [0:MAX_PAYLOAD-1];

    t_frame_result     pending_results [$];
    logic              typed_pending = 1'b0;
    t_frame_result     typed_want;

    int fail_count    = 0;
    int results_seen  = 0;
    int bytes_sent    = 0;
    int frames_good   = 0;
    int frames_bad    = 0;
    int sync_settings = 1;
    int cycle_count   = 0;

    // Idling knobs for both sides.
    int gap_max    = 0;
    int burst_max  = 0;
    int burst_left = 0;
    int pop_pct    = 100;
    int stall_max  = 0;
    int stall_left = 0;

    sum_checked_frame_receiver #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_sync_byte(i_cfg_sync_byte),
        .push           (push),
        .full           (full),
        .i_rx_byte      (i_rx_byte),
        .empty          (empty),
        .pop            (pop),
        .o_data_byte    (o_data_byte),
        .o_has_data     (o_has_data),
        .o_last         (o_last),
        .o_frame_status (o_frame_status),
        .o_frame_length (o_frame_length)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** sum_checked_frame_receiver: FAILED **");
            $finish;
        end
    end

    // Receiver side: pops at a set rate, with stalls of random length.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            pop <= 1'b0;
        end else if ($urandom_range(0, 99) < pop_pct) begin
            pop <= 1'b1;
        end else begin
            pop <= 1'b0;
            stall_left <= $urandom_range(0, stall_max);
        end
    end

    task automatic cmp_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_frame_result head;
        if (i_rst_n && pop && !empty) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: data_byte %0d", o_data_byte);
                fail_count++;
            end else begin
                head = pending_results.pop_front();
                cmp_field("data_byte", head.data_byte, o_data_byte);
                cmp_field("has_data", head.has_data, o_has_data);
                cmp_field("last", head.last, o_last);
                cmp_field("frame_status", head.frame_status, o_frame_status);
                cmp_field("frame_length", head.frame_length, o_frame_length);
                results_seen++;
            end
        end
    end

    // Advances the frame model by one accepted byte and queues what it yields.
    task automatic absorb_byte(input logic [scfr_pkg::BYTE_W-1:0] b);
        logic [scfr_pkg::SUM_W-1:0] sent_sum;
        case (rx_phase)
            scfr_pkg::PH_HUNT: begin
                if (b == sync_now) begin
                    rx_phase = scfr_pkg::PH_LEN;
                    byte_sum = '0;
                    got_count = '0;
                end
            end
            scfr_pkg::PH_LEN: begin
                want_len = (b > MAX_PAYLOAD) ? scfr_pkg::LEN_W'(MAX_PAYLOAD) :
                           b[scfr_pkg::LEN_W-1:0];
                got_count = '0;
                byte_sum = '0;
                rx_phase = (want_len == 0) ? scfr_pkg::PH_CKLO : scfr_pkg::PH_DATA;
            end
            scfr_pkg::PH_DATA: begin
                payload_mem[got_count[ADDR_W-1:0]] = b;
                byte_sum = byte_sum + b;
                got_count = got_count + 1'b1;
                if (got_count >= want_len)
                    rx_phase = scfr_pkg::PH_CKLO;
            end
            scfr_pkg::PH_CKLO: begin
                sum_lo = b;
                rx_phase = scfr_pkg::PH_CKHI;
            end
            scfr_pkg::PH_CKHI: begin
                sent_sum = {b, sum_lo};
                if (sent_sum != byte_sum)
                    frames_bad++;
                else
                    frames_good++;
                if (typed_pending) begin
                    pending_results.push_back(typed_want);
                    typed_pending = 1'b0;
                end else if (sent_sum != byte_sum) begin
                    pending_results.push_back({8'h00, 1'b0, 1'b1, 1'b1, want_len});
                end else if (want_len == 0) begin
                    pending_results.push_back({8'h00, 1'b0, 1'b1, 1'b0, 6'd0});
                end else begin
                    for (int i = 0; i < want_len; i++)
                        pending_results.push_back({payload_mem[i], 1'b1,
                                                   1'(i + 1 == want_len), 1'b0, want_len});
                end
                rx_phase = scfr_pkg::PH_HUNT;
                got_count = '0;
                byte_sum = '0;
            end
            default: rx_phase = scfr_pkg::PH_HUNT;
        endcase
    endtask

    task automatic send_byte(input logic [scfr_pkg::BYTE_W-1:0] b);
        int gap;
        push <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (full);
        absorb_byte(b);
        bytes_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, burst_max);
            gap = $urandom_range(0, gap_max);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic hold_input();
        push <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
    endtask

    // Sends noise, then a frame; cut >= 0 stops after that many payload bytes.
    task automatic send_frame(input int noise_n, input logic [7:0] len_byte, input t_fill fill,
                              input logic [7:0] seed, input logic [scfr_pkg::SUM_W-1:0] bad_mask,
                              input int cut);
        int n;
        logic [scfr_pkg::SUM_W-1:0] sum;
        logic [7:0] p;
        n = (len_byte > MAX_PAYLOAD) ? MAX_PAYLOAD : len_byte;
        sum = '0;
        repeat (noise_n) begin
            p = 8'($urandom_range(0, 255));
            send_byte((p == sync_now) ? ~p : p);
        end
        send_byte(sync_now);
        send_byte(len_byte);
        for (int i = 0; i < n; i++) begin
            if (cut >= 0 && i >= cut)
                return;
            case (fill)
                FILL_CONST: p = seed;
                FILL_RAMP:  p = seed + 8'(i);
                default:    p = 8'($urandom_range(0, 255));
            endcase
            sum = sum + p;
            send_byte(p);
        end
        if (cut >= 0)
            return;
        sum = sum ^ bad_mask;
        send_byte(sum[7:0]);
        send_byte(sum[15:8]);
    endtask

    // Finishes any open frame, then waits for every result to drain.
    task automatic settle();
        while (rx_phase != scfr_pkg::PH_HUNT)
            send_byte(8'h00);
        hold_input();
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    task automatic write_sync(input logic [scfr_pkg::BYTE_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_sync_byte <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sync_now = v;
        sync_settings++;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_frames(input int byte_budget, input bit with_pause);
        int stop_at;
        int pick;
        int len;
        logic [scfr_pkg::SUM_W-1:0] mask;
        stop_at = bytes_sent + byte_budget;
        while (bytes_sent < stop_at) begin
            if (with_pause && bytes_sent >= stop_at - byte_budget / 2) begin
                // Let the block drain completely once before carrying on.
                hold_input();
                while (pending_results.size() != 0)
                    @(posedge i_clk);
                with_pause = 1'b0;
            end
            pick = $urandom_range(0, 99);
            len = $urandom_range(0, 99);
            if (len < 80)
                len = $urandom_range(0, 8);
            else if (len < 95)
                len = $urandom_range(9, 31);
            else
                len = MAX_PAYLOAD;
            mask = ($urandom_range(0, 99) < 20) ? 16'($urandom_range(1, 65535)) : '0;
            if (pick < 75) begin
                send_frame($urandom_range(0, 2), 8'(len), FILL_RAND, 8'h00, mask, -1);
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 6))
                    send_byte(($urandom_range(0, 3) == 0) ? sync_now : 8'($urandom_range(0, 255)));
            end else if (pick < 92) begin
                send_frame(0, 8'(len), FILL_RAND, 8'h00, '0, $urandom_range(0, len));
            end else begin
                send_frame(0, 8'($urandom_range(33, 255)), FILL_RAND, 8'h00, mask, -1);
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_sync_byte = '0;
        push = 1'b0;
        i_rx_byte = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed frames with the sync byte left at its reset value.
        gap_max = 2;
        burst_max = 3;
        pop_pct = 80;
        stall_max = 3;
        for (int r = 0; r < PLAN_ROWS; r++) begin
            if (frame_plan[r].typed) begin
                typed_want = frame_plan[r].want;
                typed_pending = 1'b1;
            end
            send_frame(frame_plan[r].noise_n, frame_plan[r].len_byte, frame_plan[r].fill,
                       frame_plan[r].seed, {15'd0, frame_plan[r].bad_sum}, -1);
        end

        // Random phases, each under its own sync byte and idling pattern.
        for (int ph = 0; ph < 4; ph++) begin
            settle();
            case (ph)
                0: begin
                    write_sync(8'h00);
                    gap_max = 0; burst_max = 0; pop_pct = 100; stall_max = 0;
                end
                1: begin
                    write_sync(8'hFF);
                    gap_max = 3; burst_max = 4; pop_pct = 60; stall_max = 4;
                end
                2: begin
                    write_sync(8'($urandom_range(1, 254)));
                    gap_max = 12; burst_max = 2; pop_pct = 30; stall_max = 20;
                end
                default: begin
                    write_sync(scfr_pkg::SYNC_RESET);
                    gap_max = 2; burst_max = 8; pop_pct = 90; stall_max = 2;
                end
            endcase
            random_frames(65, ph == 2);
        end

        settle();
        $display("Sent %0d bytes: %0d frames passed the sum, %0d were dropped.",
                 bytes_sent, frames_good, frames_bad);
        $display("Checked %0d results under %0d sync byte settings.",
                 results_seen, sync_settings);
        if (fail_count == 0)
            $display("** sum_checked_frame_receiver: PASSED **");
        else
            $display("** sum_checked_frame_receiver: FAILED **");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/scfr_pkg.sv
rtl/scfr_ram.sv
rtl/scfr_front.sv
rtl/scfr_desc_fifo.sv
rtl/scfr_back.sv
rtl/sum_checked_frame_receiver.sv
rtl/scfr_checker.sv
test/sum_checked_frame_receiver_tb.sv
